/* hw/rtl/smsf_pkg.sv */
`timescale 1ns / 1ps
package smsf_pkg;

   localparam int WINDOW   = 32;
   localparam int SAMPLE_W = 10;
   localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W    = $clog2(WINDOW + 1);
   localparam int BIT_W    = $clog2(SAMPLE_W);

   // Ranks (zero based) of the order statistics that form the median.
   localparam bit WIN_ODD  = (WINDOW % 2) == 1;
   localparam int RANK_LO  = WIN_ODD ? (WINDOW - 1) / 2 : WINDOW / 2 - 1;
   localparam int RANK_HI  = WINDOW / 2;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [IDX_W-1:0]    index_type;
   typedef logic [CNT_W-1:0]    count_type;
   typedef logic [BIT_W-1:0]    bit_sel_type;

endpackage

/* hw/rtl/smsf_req_if.sv */
`timescale 1ns / 1ps
interface smsf_req_if import smsf_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

/* hw/rtl/smsf_rsp_if.sv */
`timescale 1ns / 1ps
interface smsf_rsp_if import smsf_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type median;

   modport source (output valid, output median, input ready);
   modport sink (input valid, input median, output ready);
endinterface

/* hw/rtl/smsf_ram.sv */
`timescale 1ns / 1ps
module smsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/sliding_median_sample_filter.sv */
`timescale 1ns / 1ps
// Operation: the single comparator and counter sweep the window RAM once per result bit,
// ten sweeps for each order statistic; an even WINDOW selects two order statistics.
// Throughput: a new transaction is accepted only after the previous result has been
// handed to the output register, since ready is held low while a sweep is in progress.
// Reset: synchronous and active high; the window reads as all zeros through per-slot
// valid bits, the write position returns to zero and both channels go idle at once.
module sliding_median_sample_filter import smsf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   smsf_req_if.sink    req_if,
   smsf_rsp_if.source  rsp_if
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]        state_ff, state_in;
   index_type         wpos_ff, wpos_in;
   logic [WINDOW-1:0] vld_ff, vld_in;
   index_type         addr_ff, addr_in;
   logic              issue_ff, issue_in;
   logic              pend_ff, pend_in;
   logic              vld_rd_ff, vld_rd_in;
   count_type         cnt_ff, cnt_in;
   bit_sel_type       bit_ff, bit_in;
   sample_type        prefix_ff, prefix_in;
   sample_type        lo_ff, lo_in;
   logic              sel_ff, sel_in;
   sample_type        res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sample_type        rsp_median_ff, rsp_median_in;

   logic              req_accept;
   logic              rd_en;
   sample_type        rd_data;
   sample_type        rd_val;
   sample_type        thr;
   logic              lt;
   count_type         cnt_sum;
   count_type         rank;
   sample_type        new_prefix;
   logic              last;
   logic [SAMPLE_W:0] mean_sum;

   assign req_accept = req_if.valid && req_if.ready;
   assign rd_en      = (state_ff == ST_SCAN) && issue_ff;

   smsf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_window (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (wpos_ff),
      .wr_data (req_if.sample),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // Radix selection: a result bit stays clear when more than rank entries lie below
   // the trial threshold.
   assign rd_val     = vld_rd_ff ? rd_data : '0;
   assign thr        = prefix_ff | (SAMPLE_W'(1) << bit_ff);
   assign lt         = rd_val < thr;
   assign cnt_sum    = cnt_ff + CNT_W'(lt);
   assign rank       = (WIN_ODD || !sel_ff) ? CNT_W'(RANK_LO) : CNT_W'(RANK_HI);
   assign new_prefix = (cnt_sum > rank) ? prefix_ff : thr;
   assign last       = pend_ff && !issue_ff;
   assign mean_sum   = {1'b0, lo_ff} + {1'b0, new_prefix};

   always_comb begin
      state_in      = state_ff;
      wpos_in       = wpos_ff;
      vld_in        = vld_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      vld_rd_in     = vld_ff[addr_ff];
      cnt_in        = cnt_ff;
      bit_in        = bit_ff;
      prefix_in     = prefix_ff;
      lo_in         = lo_ff;
      sel_in        = sel_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_median_in = rsp_median_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               vld_in[wpos_ff] = 1'b1;
               wpos_in   = (wpos_ff == IDX_W'(WINDOW - 1)) ? '0 : wpos_ff + IDX_W'(1);
               state_in  = ST_SCAN;
               addr_in   = '0;
               issue_in  = 1'b1;
               cnt_in    = '0;
               bit_in    = BIT_W'(SAMPLE_W - 1);
               prefix_in = '0;
               sel_in    = 1'b0;
            end
         end
         ST_SCAN: begin
            pend_in = issue_ff;
            if (issue_ff) begin
               addr_in = addr_ff + IDX_W'(1);
               if (addr_ff == IDX_W'(WINDOW - 1)) begin
                  issue_in = 1'b0;
               end
            end
            if (pend_ff) begin
               cnt_in = cnt_sum;
            end
            if (last) begin
               cnt_in    = '0;
               addr_in   = '0;
               issue_in  = 1'b1;
               prefix_in = new_prefix;
               if (bit_ff != '0) begin
                  bit_in = bit_ff - BIT_W'(1);
               end else begin
                  bit_in    = BIT_W'(SAMPLE_W - 1);
                  prefix_in = '0;
                  if (!WIN_ODD && !sel_ff) begin
                     sel_in = 1'b1;
                     lo_in  = new_prefix;
                  end else begin
                     res_in   = WIN_ODD ? new_prefix : mean_sum[SAMPLE_W:1];
                     issue_in = 1'b0;
                     state_in = ST_OUT;
                  end
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_median_in = res_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wpos_ff      <= '0;
         vld_ff       <= '0;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wpos_ff      <= wpos_in;
         vld_ff       <= vld_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      vld_rd_ff     <= vld_rd_in;
      cnt_ff        <= cnt_in;
      bit_ff        <= bit_in;
      prefix_ff     <= prefix_in;
      lo_ff         <= lo_in;
      sel_ff        <= sel_in;
      res_ff        <= res_in;
      rsp_median_ff <= rsp_median_in;
   end

   assign req_if.ready  = (state_ff == ST_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.median = rsp_median_ff;

   // A transaction always starts a window sweep.
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SCAN) && issue_ff && (addr_ff == '0))
      else $error("accepted transaction did not start a sweep");

   // Data return only follows an issued read.
   a_pend_issue: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(rd_en))
      else $error("read data flagged without a preceding read");

   // The running count never passes the number of window entries.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= CNT_W'(WINDOW)))
      else $error("comparison count exceeds window size");

   // A new result never appears while a transaction is being processed.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output state");

endmodule
